### hw/rtl/pe_pkg.sv
// Shared types and constants for the polynomial evaluator.
package pe_pkg;

  localparam int NUM_COEF  = 7;   // coefficient registers coef_0..coef_6
  localparam int COEF_W    = 16;  // signed Q8.8
  localparam int DEG_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int ACC_W     = 48;  // signed Q40.8
  localparam int FRAC_W    = 8;
  localparam int PROD_W    = ACC_W + COEF_W;
  localparam int SUM_W     = PROD_W - FRAC_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd1;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [DEG_W-1:0]         deg_t;

  // one pipeline word between Horner steps
  typedef struct packed {
    logic  valid;
    logic  ovf;
    coef_t x;
    acc_t  acc;
  } stage_t;

endpackage

### hw/rtl/pe_in_if.sv
// Input channel: one evaluation point per word.
interface pe_in_if import pe_pkg::*; ;
  logic  valid;
  logic  ready;
  coef_t point;

  modport source (output valid, output point, input ready);
  modport sink   (input valid, input point, output ready);
endinterface

### hw/rtl/pe_out_if.sv
// Result channel: polynomial value and overflow flag per word.
interface pe_out_if import pe_pkg::*; ;
  logic valid;
  logic ready;
  acc_t value;
  logic overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink   (input valid, input value, input overflow, output ready);
endinterface

### hw/rtl/pe_cfg.sv
// Configuration registers and effective coefficient selection.
module pe_cfg import pe_pkg::*; #(
  parameter int N_STEP = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output coef_t                coef_eff [N_STEP+1]
);

  deg_t  degree_r;
  coef_t coef_r [NUM_COEF];
  deg_t  deg_eff;
  logic [CFG_IDX_W-1:0] coef_idx;

  assign coef_idx = cfg_index - REG_COEF0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= '0;
      for (int i = 0; i < NUM_COEF; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEGREE: degree_r <= cfg_data[DEG_W-1:0];
        default: coef_r[coef_idx] <= coef_t'(cfg_data);
      endcase
    end
  end

  // degree above the pipeline depth clamps to it
  assign deg_eff = (int'(degree_r) > N_STEP) ? DEG_W'(N_STEP) : degree_r;

  // terms above the degree read as zero
  always_comb begin
    for (int k = 0; k <= N_STEP; k++)
      coef_eff[k] = (k <= int'(deg_eff)) ? coef_r[k] : '0;
  end

endmodule

### hw/rtl/pe_step.sv
// One Horner step: multiply stage, then shift/add/saturate stage.
module pe_step import pe_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  coef_t  coef,
  input  stage_t up,
  output logic   up_ready,
  output stage_t dn,
  input  logic   dn_ready
);

  // stage A: product
  logic                     a_v_r, a_ovf_r, a_ready, a_ld;
  coef_t                    a_x_r;
  logic signed [PROD_W-1:0] a_prod_r, a_prod_nxt, acc_ext, x_ext;
  // stage B: accumulate
  logic                     b_v_r, b_ovf_r, b_ready, b_ld, b_ovf_nxt;
  coef_t                    b_x_r;
  acc_t                     b_acc_r, b_acc_nxt;
  logic signed [SUM_W-1:0]  sum, shifted, coef_sh;
  logic                     pos_sat, neg_sat;

  assign b_ready  = !b_v_r || dn_ready;
  assign a_ready  = !a_v_r || b_ready;
  assign up_ready = a_ready;
  assign a_ld     = a_ready && up.valid;
  assign b_ld     = b_ready && a_v_r;

  assign acc_ext    = {{(PROD_W-ACC_W){up.acc[ACC_W-1]}}, up.acc};
  assign x_ext      = {{(PROD_W-COEF_W){up.x[COEF_W-1]}}, up.x};
  assign a_prod_nxt = acc_ext * x_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (a_ready) a_v_r <= up.valid;
  end

  always_ff @(posedge clk) begin
    if (a_ld) begin
      a_prod_r <= a_prod_nxt;
      a_x_r    <= up.x;
      a_ovf_r  <= up.ovf;
    end
  end

  // floor shift is an arithmetic shift; then add coef in Q40.8
  assign shifted = {a_prod_r[PROD_W-1], a_prod_r[PROD_W-1:FRAC_W]};
  assign coef_sh = {{(SUM_W-COEF_W-FRAC_W){coef[COEF_W-1]}}, coef, {FRAC_W{1'b0}}};
  assign sum     = shifted + coef_sh;
  assign pos_sat = !sum[SUM_W-1] && (|sum[SUM_W-2:ACC_W-1]);
  assign neg_sat = sum[SUM_W-1] && !(&sum[SUM_W-2:ACC_W-1]);

  always_comb begin
    b_acc_nxt = sum[ACC_W-1:0];
    if (pos_sat) b_acc_nxt = {1'b0, {(ACC_W-1){1'b1}}};
    else if (neg_sat) b_acc_nxt = {1'b1, {(ACC_W-1){1'b0}}};
  end
  assign b_ovf_nxt = a_ovf_r || pos_sat || neg_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (b_ready) b_v_r <= a_v_r;
  end

  always_ff @(posedge clk) begin
    if (b_ld) begin
      b_acc_r <= b_acc_nxt;
      b_x_r   <= a_x_r;
      b_ovf_r <= b_ovf_nxt;
    end
  end

  assign dn.valid = b_v_r;
  assign dn.ovf   = b_ovf_r;
  assign dn.x     = b_x_r;
  assign dn.acc   = b_acc_r;

  // overflow from an earlier step is never dropped
  a_ovf_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (b_ld && a_ovf_r) |=> dn.ovf)
    else $error("pe_step: overflow flag lost");

  // zero accumulator gives zero product
  a_zero_prod: assert property (@(posedge clk) disable iff (!rst_n)
    (a_ld && up.acc == '0) |=> (a_prod_r == '0))
    else $error("pe_step: product of zero accumulator not zero");

  // a stalled result holds in the output stage
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_v_r && !dn_ready) |=> (b_v_r && $stable(b_acc_r) && $stable(b_ovf_r)))
    else $error("pe_step: stalled result changed");

endmodule

### hw/rtl/polynomial_evaluate_top.sv
// Top level of the pipelined Horner polynomial evaluator.
//
//  channel   dir  handshake        payload
//  in_chan   in   valid/ready      point    s16 Q8.8
//  out_chan  out  valid/ready      value    s48 Q40.8, overflow 1b
//  cfg_*     in   cfg_we           cfg_index 3b, cfg_data 16b
//
// Each Horner step: a multiplier stage, then a shift/add/saturate stage.
// One word is taken per cycle whenever the output side keeps up.
// Each stage has its own valid bit and ready; a stall backs up stage by
// stage and fills bubbles, so no word is dropped or duplicated.
// Synchronous active-low reset clears valid bits and config registers.
// Config is read live by every stage; write it only while idle.
module polynomial_evaluate_top import pe_pkg::*; #(
  parameter int MAX_DEGREE = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pe_in_if.sink                in_chan,
  pe_out_if.source             out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  // number of pipelined Horner steps
  localparam int N_STEP = (MAX_DEGREE < NUM_COEF - 1) ? MAX_DEGREE : NUM_COEF - 1;

  coef_t  coef_eff [N_STEP+1];
  stage_t chain    [N_STEP+1];
  logic   rdy      [N_STEP+1];

  pe_cfg #(.N_STEP(N_STEP)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef_eff  (coef_eff)
  );

  // Accumulator starts at the top coefficient in Q40.8. With a smaller
  // degree that term is zero and the first steps just yield zero plus
  // the next term, which is exactly the shorter Horner chain.
  assign chain[0].valid = in_chan.valid;
  assign chain[0].ovf   = 1'b0;
  assign chain[0].x     = in_chan.point;
  assign chain[0].acc   = {{(ACC_W-COEF_W-FRAC_W){coef_eff[N_STEP][COEF_W-1]}},
                           coef_eff[N_STEP], {FRAC_W{1'b0}}};
  assign in_chan.ready  = rdy[0];

  for (genvar i = 0; i < N_STEP; i++) begin : g_step
    pe_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .coef     (coef_eff[N_STEP-1-i]),
      .up       (chain[i]),
      .up_ready (rdy[i]),
      .dn       (chain[i+1]),
      .dn_ready (rdy[i+1])
    );
  end

  assign out_chan.valid    = chain[N_STEP].valid;
  assign out_chan.value    = chain[N_STEP].acc;
  assign out_chan.overflow = chain[N_STEP].ovf;
  assign rdy[N_STEP]       = out_chan.ready;

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("top: output valid after reset");

  // a ready output never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.ready |-> in_chan.ready)
    else $error("top: input stalled with output ready");

  // with all stages empty, an accepted word cannot appear at once
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && !out_chan.valid && !chain[N_STEP-1].valid
     && out_chan.ready && N_STEP == 1) |=> !out_chan.valid)
    else $error("top: word skipped the pipeline");

endmodule

### verif/pe_result_monitor.sv
// Channel monitor for the polynomial evaluator: Horner prediction and in-order result compare.
module pe_result_monitor import pe_pkg::*; #(
  parameter int MAX_DEGREE = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pe_in_if                     in_mon,
  pe_out_if                    out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    acc_t value;
    logic overflow;
  } poly_result_t;

  localparam longint SAT_HI   = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint SAT_LO   = -(longint'(1) <<< (ACC_W - 1));
  localparam int     TOP_TERM = (MAX_DEGREE < NUM_COEF - 1) ? MAX_DEGREE : NUM_COEF - 1;

  deg_t         degree_reg;
  coef_t        coef_reg [NUM_COEF];
  poly_result_t expected_results [$];
  int           error_count;

  // Horner from the top term down; floor shift, saturate after every step
  function automatic poly_result_t horner_eval(coef_t x);
    poly_result_t r;
    longint       acc;
    int           top;
    r.overflow = 1'b0;
    top = (int'(degree_reg) > TOP_TERM) ? TOP_TERM : int'(degree_reg);
    acc = longint'(coef_reg[top]) <<< FRAC_W;
    for (int i = top - 1; i >= 0; i--) begin
      acc = ((acc * longint'(x)) >>> FRAC_W) + (longint'(coef_reg[i]) <<< FRAC_W);
      if (acc > SAT_HI) begin
        acc = SAT_HI;
        r.overflow = 1'b1;
      end else if (acc < SAT_LO) begin
        acc = SAT_LO;
        r.overflow = 1'b1;
      end
    end
    r.value = acc[ACC_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    poly_result_t want;
    if (!rst_n) begin
      degree_reg <= '0;
      for (int k = 0; k < NUM_COEF; k++) coef_reg[k] <= '0;
      expected_results.delete();
      error_count = 0;
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DEGREE) begin
          degree_reg <= cfg_data[DEG_W-1:0];
        end else begin
          coef_reg[cfg_index - REG_COEF0] <= coef_t'(cfg_data);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_results.insert(expected_results.size(), horner_eval(in_mon.point));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected word: value %0d overflow %0b",
                 $signed(out_mon.value), out_mon.overflow);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_mon.value !== want.value) begin
            $error("value: expected %0d actual %0d",
                   $signed(want.value), $signed(out_mon.value));
            error_count++;
          end
          if (out_mon.overflow !== want.overflow) begin
            $error("overflow: expected %0b actual %0b", want.overflow, out_mon.overflow);
            error_count++;
          end
        end
      end
      outstanding <= expected_results.size();
      mismatches  <= error_count;
    end
  end

endmodule

### verif/polynomial_evaluate_top_test.sv
// Stimulus and verdict for the polynomial evaluator, with the channel monitor beside the block.
module polynomial_evaluate_top_test;
  import pe_pkg::*;

  localparam int MAX_DEGREE   = 6;
  localparam int LATENCY      = 2 * 6;     // two stages per Horner step
  localparam int RANDOM_ITEMS = 1450;
  localparam int CALM_ITEMS   = 150;       // final stretch, no idling on either side
  // worst case per word: an idle burst in + a stall burst out, plus drains and reloads
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  pe_in_if  in_chan ();
  pe_out_if out_chan ();

  int failures;
  int outstanding;
  int cycle_count = 0;
  bit calm = 1'b0;

  // staging for the next register load
  logic [CFG_DAT_W-1:0] degree_word;
  coef_t                coef_set [NUM_COEF];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  polynomial_evaluate_top #(.MAX_DEGREE(MAX_DEGREE)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pe_result_monitor #(.MAX_DEGREE(MAX_DEGREE)) u_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (failures),
    .outstanding (outstanding)
  );

  // Watchdog: a hung handshake or a lost word ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("polynomial_evaluate_top verification failed");
      $finish;
    end
  end

  // Result side: random stall bursts between ready runs of varied length.
  // Long ready runs give stretches with no backpressure at all.
  initial begin
    forever begin
      if (!calm && rst_n === 1'b1 && $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 80 : 20)) @(posedge clk);
      end
    end
  end

  // Writes the degree and all seven coefficients, one register per cycle.
  // Only called with the pipe empty: the block reads config live.
  task automatic load_config();
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEGREE;
    cfg_data  <= degree_word;
    @(posedge clk);
    for (int k = 0; k < NUM_COEF; k++) begin
      cfg_index <= REG_COEF0 + CFG_IDX_W'(k);
      cfg_data  <= coef_set[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Stop sending and wait until every predicted word has come back.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // One point through the input handshake, with an occasional idle burst in front.
  // valid stays high across back-to-back words.
  task automatic send_point(input coef_t p);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.point <= p;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
  endtask

  // Points: small magnitudes keep degree-6 sums out of saturation,
  // full range and corners drive the clamps and the sign bits.
  function automatic coef_t pick_point();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return coef_t'($urandom_range(0, 1024) - 512);
    if (sel < 8) return coef_t'($urandom());
    case ($urandom_range(0, 6))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'sh0100;
      4:       return 16'shFF00;
      5:       return 16'shFFFF;
      default: return 16'sh0001;
    endcase
  endfunction

  function automatic coef_t pick_coef(input int style);
    case (style)
      0: return coef_t'($urandom());
      1: return coef_t'($urandom_range(0, 512) - 256);     // |c| <= 1.0
      2: return coef_t'($urandom_range(0, 4096) - 2048);   // |c| <= 8.0
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          default: return coef_t'($urandom());
        endcase
      end
    endcase
  endfunction

  initial begin : stimulus
    int phase;
    int sent;
    int n;
    int style;
    logic [DEG_W-1:0] deg;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_DEGREE;
    cfg_data      <= '0;
    in_chan.valid <= 1'b0;
    in_chan.point <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed ----
    // registers straight out of reset: degree 0, all coefs zero, result is zero
    send_point(16'sh7FFF);
    send_point(16'sh8000);

    // top degree, all coefs at the positive limit: saturation both ways, x=0, tiny x
    drain();
    degree_word = 16'h0006;
    for (int k = 0; k < NUM_COEF; k++) coef_set[k] = 16'sh7FFF;
    load_config();
    send_point(16'sh7FFF);
    send_point(16'sh8000);
    send_point(16'sh0000);
    send_point(16'sh0001);
    send_point(16'shFFFF);

    // degree field of 7 clamps to 6; upper data bits set; coefs at the negative limit
    drain();
    degree_word = 16'hFFFF;
    for (int k = 0; k < NUM_COEF; k++) coef_set[k] = 16'sh8000;
    load_config();
    send_point(16'sh7FFF);
    send_point(16'sh8000);
    send_point(16'sh0100);
    send_point(16'shFF00);

    // degree 0: every coef above the constant must be ignored
    drain();
    degree_word = 16'hFFF8;
    coef_set[0] = 16'sh8000;
    for (int k = 1; k < NUM_COEF; k++) coef_set[k] = coef_t'($urandom());
    load_config();
    send_point(coef_t'($urandom()));
    send_point(coef_t'($urandom()));

    // small cubic with odd LSBs: floor rounding on negative products
    drain();
    degree_word = 16'h0003;
    coef_set[0] = 16'sh0001;
    coef_set[1] = 16'shFFFF;
    coef_set[2] = 16'sh0003;
    coef_set[3] = 16'sh0001;
    for (int k = 4; k < NUM_COEF; k++) coef_set[k] = coef_t'($urandom());
    load_config();
    send_point(16'shFF80);
    send_point(16'sh0080);
    send_point(16'shFFFF);

    // ---- random phases, one register setting each ----
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      n = $urandom_range(60, 220);
      if (sent + n > RANDOM_ITEMS - CALM_ITEMS) n = RANDOM_ITEMS - CALM_ITEMS - sent;
      if (n <= 0) begin
        n    = RANDOM_ITEMS - sent;
        calm = 1'b1;
      end
      // first phases pin the degree extremes, then anything goes
      case (phase)
        0:       deg = 3'd6;
        1:       deg = 3'd0;
        2:       deg = 3'd7;
        default: deg = DEG_W'($urandom_range(0, 7));
      endcase
      degree_word      = CFG_DAT_W'($urandom());
      degree_word[2:0] = deg;
      style = $urandom_range(0, 3);
      for (int k = 0; k < NUM_COEF; k++) coef_set[k] = pick_coef(style);
      drain();
      load_config();
      for (int j = 0; j < n; j++) begin
        // now and then hold off until the pipe has fully emptied
        if (!calm && $urandom_range(0, 299) == 0) drain();
        send_point(pick_point());
      end
      sent  += n;
      phase++;
    end

    // ---- wind down ----
    drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("polynomial_evaluate_top verification clean");
    end else begin
      $display("polynomial_evaluate_top verification failed");
    end
    $finish;
  end

endmodule
